FILE: hw/rtl/rsrb_pkg.sv
package rsrb_pkg;

    // default slot count of the reorder window
    localparam int SLOTS_DEF = 64;

    // field widths
    localparam int SEQ_W  = 16;
    localparam int TS_W   = 32;
    localparam int REF_W  = 32;
    localparam int LEN_W  = 16;
    localparam int STAT_W = 3;

    // request types
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // result status codes
    typedef logic [STAT_W-1:0] t_status;
    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_OVERFLOW = 3'd1;
    localparam t_status ST_EMPTY    = 3'd2;
    localparam t_status ST_GAP      = 3'd3;
    localparam t_status ST_LATE     = 3'd4;

    // one slot of the buffer memory
    typedef struct packed {
        logic             valid;
        logic [SEQ_W-1:0] seq;
        logic             marker;
        logic [TS_W-1:0]  time_stamp;
        logic [REF_W-1:0] payload_ref;
        logic [LEN_W-1:0] payload_len;
    } t_slot;

endpackage

FILE: hw/rtl/rtp_sequence_reorder_buffer.sv
// channel   | valid        | stall        | payload
// ----------+--------------+--------------+-------------------------------------------
// request   | i_req_valid  | o_req_stall  | i_req_type i_seq_num i_marker i_time_stamp
//           |              |              | i_payload_ref i_payload_len
// result    | o_res_valid  | i_res_stall  | o_status o_out_valid o_out_* o_occupancy
//           |              |              | o_is_empty o_is_full
//
// every request passes through the accept cycle (which also issues the head slot read) and
// then an update state; a pop works there on the registered read data of the slot memory.
// after reset a clearing pass writes every slot invalid, one slot a cycle;
// no request is taken during it.
// the result sits in an output register; a request is taken when that register is empty
// or drains in the same cycle, so a stalled result holds off at most the next request.
module rtp_sequence_reorder_buffer #(
    parameter int SLOTS = rsrb_pkg::SLOTS_DEF,
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int CW = $clog2(SLOTS + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request channel
    input  logic                         i_req_valid,
    output logic                         o_req_stall,
    input  logic                         i_req_type,
    input  logic [rsrb_pkg::SEQ_W-1:0]   i_seq_num,
    input  logic                         i_marker,
    input  logic [rsrb_pkg::TS_W-1:0]    i_time_stamp,
    input  logic [rsrb_pkg::REF_W-1:0]   i_payload_ref,
    input  logic [rsrb_pkg::LEN_W-1:0]   i_payload_len,
    // result channel
    output logic                         o_res_valid,
    input  logic                         i_res_stall,
    output logic [rsrb_pkg::STAT_W-1:0]  o_status,
    output logic                         o_out_valid,
    output logic [rsrb_pkg::SEQ_W-1:0]   o_out_seq_num,
    output logic                         o_out_marker,
    output logic [rsrb_pkg::TS_W-1:0]    o_out_time_stamp,
    output logic [rsrb_pkg::REF_W-1:0]   o_out_payload_ref,
    output logic [rsrb_pkg::LEN_W-1:0]   o_out_payload_len,
    output logic [CW-1:0]                o_occupancy,
    output logic                         o_is_empty,
    output logic                         o_is_full
);

    // wide enough for sequence differences plus pointers
    localparam int XW = rsrb_pkg::SEQ_W + 1;
    localparam logic [XW-1:0] SLOTS_X = XW'(SLOTS);
    localparam logic [AW-1:0] LAST_IDX = AW'(SLOTS - 1);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_PUSH  = 4'b0100,
        S_POP   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // slot memory
    rsrb_pkg::t_slot r_mem [SLOTS];
    rsrb_pkg::t_slot r_rd;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    rsrb_pkg::t_slot wr_data;

    // window state
    logic [AW-1:0]                r_head, n_head;
    logic [AW-1:0]                r_tail, n_tail;
    logic [CW-1:0]                r_span, n_span;
    logic [rsrb_pkg::SEQ_W-1:0]   r_newest, n_newest;
    logic [AW-1:0]                r_clr_idx;

    // captured request
    logic [rsrb_pkg::SEQ_W-1:0]   r_seq;
    logic                         r_marker;
    logic [rsrb_pkg::TS_W-1:0]    r_time_stamp;
    logic [rsrb_pkg::REF_W-1:0]   r_payload_ref;
    logic [rsrb_pkg::LEN_W-1:0]   r_payload_len;
    logic [rsrb_pkg::SEQ_W-1:0]   r_diff;

    // output register
    logic                         r_res_valid;
    rsrb_pkg::t_status            r_status, n_status;
    logic                         r_out_valid, n_out_valid;
    logic [rsrb_pkg::SEQ_W-1:0]   r_out_seq;
    logic                         r_out_marker;
    logic [rsrb_pkg::TS_W-1:0]    r_out_time;
    logic [rsrb_pkg::REF_W-1:0]   r_out_ref;
    logic [rsrb_pkg::LEN_W-1:0]   r_out_len;
    logic                         finish;

    logic accept;
    logic res_free;

    // push placement
    logic [XW-1:0]              diff_x, back_x, tail_x, span_x, last_x;
    logic [XW-1:0]              sum_new, sum_tail, pos_x;
    logic [rsrb_pkg::SEQ_W-1:0] back;
    logic [AW-1:0]              last_idx, new_idx, new_tail, pos_idx, tail_inc;
    logic                       is_dup, is_later, overflow, late, in_window;

    // handshake
    assign res_free    = !r_res_valid || !i_res_stall;
    assign o_req_stall = (r_state != S_IDLE) || !res_free;
    assign accept      = i_req_valid && !o_req_stall;
    assign finish      = (r_state == S_PUSH) || (r_state == S_POP);

    // slot placement arithmetic
    always_comb begin
        diff_x    = {1'b0, r_diff};
        back      = rsrb_pkg::SEQ_W'(~r_diff + 1'b1);
        back_x    = {1'b0, back};
        tail_x    = XW'(r_tail);
        span_x    = XW'(r_span);
        last_idx  = (r_tail == '0) ? LAST_IDX : r_tail - 1'b1;
        last_x    = XW'(last_idx);
        tail_inc  = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
        is_dup    = (r_diff == '0);
        is_later  = !r_diff[rsrb_pkg::SEQ_W-1] && !is_dup;
        overflow  = (span_x + diff_x) > SLOTS_X;
        late      = back_x >= SLOTS_X;
        in_window = back_x < span_x;
        // newest slot for a later packet and the tail after it
        sum_new   = tail_x + diff_x - 1'b1;
        sum_tail  = tail_x + diff_x;
        new_idx   = (sum_new >= SLOTS_X) ? AW'(sum_new - SLOTS_X) : AW'(sum_new);
        new_tail  = (sum_tail >= SLOTS_X) ? AW'(sum_tail - SLOTS_X) : AW'(sum_tail);
        // slot for an earlier packet
        pos_x     = (last_x >= back_x) ? last_x - back_x : last_x + SLOTS_X - back_x;
        pos_idx   = AW'(pos_x);
    end

    // next state, window update and memory write
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_span      = r_span;
        n_newest    = r_newest;
        n_status    = rsrb_pkg::ST_OK;
        n_out_valid = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_tail;
        wr_data     = '{valid: 1'b1, seq: r_seq, marker: r_marker,
                        time_stamp: r_time_stamp, payload_ref: r_payload_ref,
                        payload_len: r_payload_len};
        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_idx;
                wr_data = '0;
                if (r_clr_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_req_type == rsrb_pkg::REQ_POP) ? S_POP : S_PUSH;
                end
            end
            S_PUSH: begin
                n_state = S_IDLE;
                if (r_span == '0) begin
                    // first packet of an empty window
                    wr_en    = 1'b1;
                    wr_addr  = r_tail;
                    n_head   = r_tail;
                    n_tail   = tail_inc;
                    n_span   = CW'(1);
                    n_newest = r_seq;
                end else if (is_dup) begin
                    wr_en   = 1'b1;
                    wr_addr = last_idx;
                end else if (is_later) begin
                    if (overflow) begin
                        n_status = rsrb_pkg::ST_OVERFLOW;
                    end else begin
                        wr_en    = 1'b1;
                        wr_addr  = new_idx;
                        n_tail   = new_tail;
                        n_span   = CW'(span_x + diff_x);
                        n_newest = r_seq;
                    end
                end else if (in_window) begin
                    wr_en   = 1'b1;
                    wr_addr = pos_idx;
                end else if (late) begin
                    n_status = rsrb_pkg::ST_LATE;
                end else begin
                    // earlier than head: the window grows backward
                    wr_en   = 1'b1;
                    wr_addr = pos_idx;
                    n_head  = pos_idx;
                    n_span  = CW'(back_x + 1'b1);
                end
            end
            S_POP: begin
                n_state = S_IDLE;
                if (r_span == '0) begin
                    n_status = rsrb_pkg::ST_EMPTY;
                end else if (!r_rd.valid) begin
                    n_status = rsrb_pkg::ST_GAP;
                end else begin
                    n_out_valid = 1'b1;
                    wr_en       = 1'b1;
                    wr_addr     = r_head;
                    wr_data     = r_rd;
                    wr_data.valid = 1'b0;
                    n_head      = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
                    n_span      = r_span - 1'b1;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // slot memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (accept) begin
            r_rd <= r_mem[r_head];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_span      <= '0;
            r_newest    <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_span   <= n_span;
            r_newest <= n_newest;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (finish) begin
                r_res_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_seq         <= i_seq_num;
            r_marker      <= i_marker;
            r_time_stamp  <= i_time_stamp;
            r_payload_ref <= i_payload_ref;
            r_payload_len <= i_payload_len;
            r_diff        <= i_seq_num - r_newest;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_status     <= n_status;
            r_out_valid  <= n_out_valid;
            r_out_seq    <= n_out_valid ? r_rd.seq : '0;
            r_out_marker <= n_out_valid ? r_rd.marker : 1'b0;
            r_out_time   <= n_out_valid ? r_rd.time_stamp : '0;
            r_out_ref    <= n_out_valid ? r_rd.payload_ref : '0;
            r_out_len    <= n_out_valid ? r_rd.payload_len : '0;
        end
    end

    // outputs
    assign o_res_valid       = r_res_valid;
    assign o_status          = r_status;
    assign o_out_valid       = r_out_valid;
    assign o_out_seq_num     = r_out_seq;
    assign o_out_marker      = r_out_marker;
    assign o_out_time_stamp  = r_out_time;
    assign o_out_payload_ref = r_out_ref;
    assign o_out_payload_len = r_out_len;
    assign o_occupancy       = r_span;
    assign o_is_empty        = (r_span == '0);
    assign o_is_full         = (r_span == CW'(SLOTS));

endmodule

FILE: dv/rtp_sequence_reorder_buffer_tb.sv
`timescale 1ns / 100ps

module rtp_sequence_reorder_buffer_tb;

    localparam int NSLOT       = rsrb_pkg::SLOTS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_CHUNKS = 8;
    localparam int CHUNK_LEN   = 56;
    localparam int DIR_ROWS    = 23;

    // predictor copies: one steers the generator, one checks the block
    localparam int GEN = 0;
    localparam int CHK = 1;

    typedef struct packed {
        logic                       typ;
        logic [rsrb_pkg::SEQ_W-1:0] seq;
        logic                       mark;
        logic [rsrb_pkg::TS_W-1:0]  ts;
        logic [rsrb_pkg::REF_W-1:0] pref;
        logic [rsrb_pkg::LEN_W-1:0] plen;
    } t_pkt_req;

    typedef struct packed {
        rsrb_pkg::t_status          status;
        logic                       ov;
        logic [rsrb_pkg::SEQ_W-1:0] seq;
        logic                       mark;
        logic [rsrb_pkg::TS_W-1:0]  ts;
        logic [rsrb_pkg::REF_W-1:0] pref;
        logic [rsrb_pkg::LEN_W-1:0] plen;
        logic [6:0]                 occ;
        logic                       emp;
        logic                       full;
    } t_pkt_res;

    typedef struct packed {
        logic              pin;
        rsrb_pkg::t_status status;
        logic [6:0]        occ;
        t_pkt_req          req;
    } t_dir_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_req_valid;
    logic                          o_req_stall;
    logic                          i_req_type;
    logic [rsrb_pkg::SEQ_W-1:0]    i_seq_num;
    logic                          i_marker;
    logic [rsrb_pkg::TS_W-1:0]     i_time_stamp;
    logic [rsrb_pkg::REF_W-1:0]    i_payload_ref;
    logic [rsrb_pkg::LEN_W-1:0]    i_payload_len;
    logic                          o_res_valid;
    logic                          i_res_stall;
    logic [rsrb_pkg::STAT_W-1:0]   o_status;
    logic                          o_out_valid;
    logic [rsrb_pkg::SEQ_W-1:0]    o_out_seq_num;
    logic                          o_out_marker;
    logic [rsrb_pkg::TS_W-1:0]     o_out_time_stamp;
    logic [rsrb_pkg::REF_W-1:0]    o_out_payload_ref;
    logic [rsrb_pkg::LEN_W-1:0]    o_out_payload_len;
    logic [6:0]                    o_occupancy;
    logic                          o_is_empty;
    logic                          o_is_full;

    // request currently offered, with its pinned expectation if any
    t_pkt_req          drv_req;
    logic              drv_pin;
    rsrb_pkg::t_status drv_pin_status;
    logic [6:0]        drv_pin_occ;

    int idle_pct;
    int stall_pct;
    int mismatches;
    int cycle_count;
    int popped_count;
    int status_seen [5];

    t_pkt_res request_results_due [$];

    // predictor state, one copy per user
    bit                         win_held   [2][NSLOT];
    t_pkt_req                   win_pkt    [2][NSLOT];
    int                         win_head   [2];
    int                         win_tail   [2];
    int                         win_span   [2];
    logic [rsrb_pkg::SEQ_W-1:0] win_newest [2];

    // directed requests: empty after reset, extremes, wrap, gaps, drops, head moved back
    t_dir_row dir_table [DIR_ROWS] = '{
        '{1'b1, rsrb_pkg::ST_EMPTY,    7'd0,
          '{rsrb_pkg::REQ_POP,  16'h0000, 1'b0, 32'h0, 32'h0, 16'h0}},
        '{1'b1, rsrb_pkg::ST_OK,       7'd1,
          '{rsrb_pkg::REQ_PUSH, 16'h0000, 1'b0, 32'h0, 32'h0, 16'h0}},
        '{1'b0, rsrb_pkg::ST_OK,       7'd0,
          '{rsrb_pkg::REQ_POP,  16'h0000, 1'b0, 32'h0, 32'h0, 16'h0}},
        '{1'b1, rsrb_pkg::ST_OK,       7'd1,
          '{rsrb_pkg::REQ_PUSH, 16'hffff, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 16'hffff}},
        '{1'b0, rsrb_pkg::ST_OK,       7'd0,
          '{rsrb_pkg::REQ_PUSH, 16'h0002, 1'b1, 32'h0000_1000, 32'h8000_0000, 16'd1200}},
        '{1'b0, rsrb_pkg::ST_OK,       7'd0,
          '{rsrb_pkg::REQ_POP,  16'h0000, 1'b0, 32'h0, 32'h0, 16'h0}},
        '{1'b1, rsrb_pkg::ST_GAP,      7'd3,
          '{rsrb_pkg::REQ_POP,  16'h0000, 1'b0, 32'h0, 32'h0, 16'h0}},
        '{1'b0, rsrb_pkg::ST_OK,       7'd0,
          '{rsrb_pkg::REQ_PUSH, 16'h0000, 1'b0, 32'h1111_2222, 32'h3333_4444, 16'd60}},
        '{1'b0, rsrb_pkg::ST_OK,       7'd0,
          '{rsrb_pkg::REQ_PUSH, 16'h0002, 1'b0, 32'h0000_2000, 32'h0bad_f00d, 16'd1400}},
        '{1'b1, rsrb_pkg::ST_OVERFLOW, 7'd3,
          '{rsrb_pkg::REQ_PUSH, 16'h0040, 1'b1, 32'h5, 32'h6, 16'h7}},
        '{1'b1, rsrb_pkg::ST_OK,       7'd64,
          '{rsrb_pkg::REQ_PUSH, 16'h003f, 1'b1, 32'h0001_0000, 32'h00ff_00ff, 16'd900}},
        '{1'b1, rsrb_pkg::ST_OVERFLOW, 7'd64,
          '{rsrb_pkg::REQ_PUSH, 16'h0040, 1'b0, 32'h8, 32'h9, 16'ha}},
        '{1'b1, rsrb_pkg::ST_LATE,     7'd64,
          '{rsrb_pkg::REQ_PUSH, 16'hffff, 1'b0, 32'hb, 32'hc, 16'hd}},
        '{1'b1, rsrb_pkg::ST_LATE,     7'd64,
          '{rsrb_pkg::REQ_PUSH, 16'h803f, 1'b1, 32'he, 32'hf, 16'h10}},
        '{1'b0, rsrb_pkg::ST_OK,       7'd0,
          '{rsrb_pkg::REQ_POP,  16'h0000, 1'b0, 32'h0, 32'h0, 16'h0}},
        '{1'b1, rsrb_pkg::ST_GAP,      7'd63,
          '{rsrb_pkg::REQ_POP,  16'h0000, 1'b0, 32'h0, 32'h0, 16'h0}},
        '{1'b0, rsrb_pkg::ST_OK,       7'd0,
          '{rsrb_pkg::REQ_PUSH, 16'h0001, 1'b1, 32'h7fff_ffff, 32'h1234_5678, 16'd1}},
        '{1'b0, rsrb_pkg::ST_OK,       7'd0,
          '{rsrb_pkg::REQ_POP,  16'h0000, 1'b0, 32'h0, 32'h0, 16'h0}},
        '{1'b0, rsrb_pkg::ST_OK,       7'd0,
          '{rsrb_pkg::REQ_POP,  16'h0000, 1'b0, 32'h0, 32'h0, 16'h0}},
        '{1'b1, rsrb_pkg::ST_GAP,      7'd61,
          '{rsrb_pkg::REQ_POP,  16'h0000, 1'b0, 32'h0, 32'h0, 16'h0}},
        '{1'b1, rsrb_pkg::ST_OK,       7'd64,
          '{rsrb_pkg::REQ_PUSH, 16'h0000, 1'b1, 32'hcafe_0000, 32'h0000_beef, 16'd1500}},
        '{1'b0, rsrb_pkg::ST_OK,       7'd0,
          '{rsrb_pkg::REQ_POP,  16'h0000, 1'b0, 32'h0, 32'h0, 16'h0}},
        '{1'b1, rsrb_pkg::ST_GAP,      7'd63,
          '{rsrb_pkg::REQ_POP,  16'h0000, 1'b0, 32'h0, 32'h0, 16'h0}}
    };

    rtp_sequence_reorder_buffer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req_valid       (i_req_valid),
        .o_req_stall       (o_req_stall),
        .i_req_type        (i_req_type),
        .i_seq_num         (i_seq_num),
        .i_marker          (i_marker),
        .i_time_stamp      (i_time_stamp),
        .i_payload_ref     (i_payload_ref),
        .i_payload_len     (i_payload_len),
        .o_res_valid       (o_res_valid),
        .i_res_stall       (i_res_stall),
        .o_status          (o_status),
        .o_out_valid       (o_out_valid),
        .o_out_seq_num     (o_out_seq_num),
        .o_out_marker      (o_out_marker),
        .o_out_time_stamp  (o_out_time_stamp),
        .o_out_payload_ref (o_out_payload_ref),
        .o_out_payload_len (o_out_payload_len),
        .o_occupancy       (o_occupancy),
        .o_is_empty        (o_is_empty),
        .o_is_full         (o_is_full)
    );

    // request payload ports follow the offered request
    assign i_req_type    = drv_req.typ;
    assign i_seq_num     = drv_req.seq;
    assign i_marker      = drv_req.mark;
    assign i_time_stamp  = drv_req.ts;
    assign i_payload_ref = drv_req.pref;
    assign i_payload_len = drv_req.plen;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void win_store(int m, int idx, t_pkt_req r);
        win_held[m][idx] = 1'b1;
        win_pkt[m][idx]  = r;
    endfunction

    function automatic void win_clear(int m, int start, int count);
        for (int i = 0; i < count; i++) begin
            win_held[m][(start + i) % NSLOT] = 1'b0;
        end
    endfunction

    // one request against the reorder window: updates copy m, returns its result
    function automatic t_pkt_res reorder_step(int m, t_pkt_req r);
        t_pkt_res                   res;
        logic [rsrb_pkg::SEQ_W-1:0] diff;
        int                         d;
        int                         back;
        int                         nidx;
        int                         pos;
        int                         h;
        res = '0;
        res.status = rsrb_pkg::ST_OK;
        if (r.typ == rsrb_pkg::REQ_PUSH) begin
            diff = r.seq - win_newest[m];
            d = int'(diff);
            if (win_span[m] == 0) begin
                // first packet into an empty window
                win_head[m] = win_tail[m];
                win_store(m, win_tail[m], r);
                win_tail[m] = (win_tail[m] + 1) % NSLOT;
                win_span[m] = 1;
                win_newest[m] = r.seq;
            end else if (d == 0) begin
                win_store(m, (win_tail[m] + NSLOT - 1) % NSLOT, r);
            end else if (d < 32768) begin
                // later packet: tail moves forward, skipped slots become gaps
                if (win_span[m] + d > NSLOT) begin
                    res.status = rsrb_pkg::ST_OVERFLOW;
                end else begin
                    win_clear(m, win_tail[m], d - 1);
                    pos = (win_tail[m] + d - 1) % NSLOT;
                    win_store(m, pos, r);
                    win_tail[m] = (pos + 1) % NSLOT;
                    win_span[m] = win_span[m] + d;
                    win_newest[m] = r.seq;
                end
            end else begin
                // earlier packet: inside the window, or the head moves back
                back = 65536 - d;
                nidx = (win_tail[m] + NSLOT - 1) % NSLOT;
                if (back < win_span[m]) begin
                    win_store(m, (nidx + NSLOT - back) % NSLOT, r);
                end else if (back + 1 > NSLOT) begin
                    res.status = rsrb_pkg::ST_LATE;
                end else begin
                    pos = (nidx + NSLOT - back) % NSLOT;
                    win_clear(m, pos, back + 1 - win_span[m]);
                    win_store(m, pos, r);
                    win_head[m] = pos;
                    win_span[m] = back + 1;
                end
            end
        end else if (win_span[m] == 0) begin
            res.status = rsrb_pkg::ST_EMPTY;
        end else begin
            h = win_head[m];
            if (!win_held[m][h]) begin
                res.status = rsrb_pkg::ST_GAP;
            end else begin
                res.ov   = 1'b1;
                res.seq  = win_pkt[m][h].seq;
                res.mark = win_pkt[m][h].mark;
                res.ts   = win_pkt[m][h].ts;
                res.pref = win_pkt[m][h].pref;
                res.plen = win_pkt[m][h].plen;
                win_held[m][h] = 1'b0;
                win_head[m] = (h + 1) % NSLOT;
                win_span[m] = win_span[m] - 1;
            end
        end
        res.occ  = 7'(win_span[m]);
        res.emp  = (win_span[m] == 0);
        res.full = (win_span[m] == NSLOT);
        return res;
    endfunction

    // mostly near-order traffic around the newest packet, plus drops and noise
    function automatic t_pkt_req next_random_request(int pop_pct);
        t_pkt_req                   r;
        int                         span;
        int                         pick;
        logic [rsrb_pkg::SEQ_W-1:0] nw;
        r.mark = 1'($urandom_range(0, 1));
        r.ts   = $urandom;
        r.pref = $urandom;
        r.plen = 16'($urandom_range(0, 65535));
        r.seq  = 16'($urandom_range(0, 65535));
        span = win_span[GEN];
        nw   = win_newest[GEN];
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < pop_pct) begin
            r.typ = rsrb_pkg::REQ_POP;
        end else begin
            r.typ = rsrb_pkg::REQ_PUSH;
            if (span == 0) begin
                // any sequence number starts a new window
            end else if (pick < 25) begin
                // fill the head slot when it is a gap
                r.seq = win_held[GEN][win_head[GEN]] ? nw + 16'd1 : nw - 16'(span - 1);
            end else if (pick < 60) begin
                r.seq = nw + 16'($urandom_range(1, 4));
            end else if (pick < 75) begin
                r.seq = nw - 16'($urandom_range(0, span - 1));
            end else if (pick < 80) begin
                r.seq = nw;
            end else if (pick < 86) begin
                r.seq = nw - 16'($urandom_range(span, NSLOT + 2));
            end else if (pick < 91) begin
                r.seq = nw + 16'($urandom_range(5, NSLOT + 6));
            end else if (pick < 94) begin
                r.seq = nw + 16'h8000;
            end
        end
        return r;
    endfunction

    // offer one request after a random idle gap, wait for it to be taken
    task automatic drive_request(input t_pkt_req r, input logic pin,
                                 input rsrb_pkg::t_status pst, input logic [6:0] pocc);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct) gap++;
        void'(reorder_step(GEN, r));
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid    <= 1'b1;
        drv_req        <= r;
        drv_pin        <= pin;
        drv_pin_status <= pst;
        drv_pin_occ    <= pocc;
        do @(posedge i_clk); while (o_req_stall);
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // result stall
    always @(posedge i_clk) begin
        i_res_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // result check first, then the prediction for the request taken at this edge
    always @(posedge i_clk) begin
        t_pkt_res want;
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            if (request_results_due.size() == 0) begin
                $display("%0t: result with none expected, status %0h", $time, o_status);
                mismatches++;
            end else begin
                want = request_results_due.pop_front();
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("out_valid", 32'(want.ov), 32'(o_out_valid));
                check_field("out_seq_num", 32'(want.seq), 32'(o_out_seq_num));
                check_field("out_marker", 32'(want.mark), 32'(o_out_marker));
                check_field("out_time_stamp", want.ts, o_out_time_stamp);
                check_field("out_payload_ref", want.pref, o_out_payload_ref);
                check_field("out_payload_len", 32'(want.plen), 32'(o_out_payload_len));
                check_field("occupancy", 32'(want.occ), 32'(o_occupancy));
                check_field("is_empty", 32'(want.emp), 32'(o_is_empty));
                check_field("is_full", 32'(want.full), 32'(o_is_full));
                status_seen[want.status]++;
                if (want.ov) popped_count++;
            end
        end
        if (i_rst_n && i_req_valid && !o_req_stall) begin
            want = reorder_step(CHK, drv_req);
            if (drv_pin) begin
                want.status = drv_pin_status;
                want.occ    = drv_pin_occ;
                want.emp    = (drv_pin_occ == 7'd0);
                want.full   = (drv_pin_occ == 7'(NSLOT));
            end
            request_results_due.push_back(want);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("rtp_sequence_reorder_buffer_tb: errors");
            $finish;
        end
    end

    // stimulus
    initial begin
        int pop_pct;
        i_rst_n        <= 1'b0;
        i_req_valid    <= 1'b0;
        drv_req        <= '0;
        drv_pin        <= 1'b0;
        drv_pin_status <= rsrb_pkg::ST_OK;
        drv_pin_occ    <= '0;
        idle_pct       = 0;
        stall_pct      = 0;
        mismatches     = 0;
        popped_count   = 0;
        for (int i = 0; i < 5; i++) status_seen[i] = 0;
        for (int m = 0; m < 2; m++) begin
            for (int s = 0; s < NSLOT; s++) begin
                win_held[m][s] = 1'b0;
                win_pkt[m][s]  = '0;
            end
            win_head[m]   = 0;
            win_tail[m]   = 0;
            win_span[m]   = 0;
            win_newest[m] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, no idling
        for (int n = 0; n < DIR_ROWS; n++) begin
            drive_request(dir_table[n].req, dir_table[n].pin, dir_table[n].status,
                          dir_table[n].occ);
        end

        // random part, cycling through the idle and stall mixes
        for (int chunk = 0; chunk < RAND_CHUNKS; chunk++) begin
            case (chunk % 4)
                0: begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1: begin
                    idle_pct = 63;
                    stall_pct <= 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct <= 63;
                end
                default: begin
                    idle_pct = 27;
                    stall_pct <= 27;
                end
            endcase
            pop_pct = $urandom_range(30, 55);
            repeat (CHUNK_LEN) begin
                drive_request(next_random_request(pop_pct), 1'b0, rsrb_pkg::ST_OK, '0);
            end
        end
        i_req_valid <= 1'b0;

        // drain, then hold off for stray results
        @(posedge i_clk);
        while (request_results_due.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("%0d requests, %0d packets popped; ok %0d, overflow %0d, empty %0d",
                 DIR_ROWS + RAND_CHUNKS * CHUNK_LEN, popped_count,
                 status_seen[rsrb_pkg::ST_OK], status_seen[rsrb_pkg::ST_OVERFLOW],
                 status_seen[rsrb_pkg::ST_EMPTY]);
        $display("head gaps %0d, late drops %0d, over four idle/stall mixes",
                 status_seen[rsrb_pkg::ST_GAP], status_seen[rsrb_pkg::ST_LATE]);
        if (mismatches == 0) begin
            $display("rtp_sequence_reorder_buffer_tb: clean");
        end else begin
            $display("rtp_sequence_reorder_buffer_tb: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/rsrb_pkg.sv
hw/rtl/rtp_sequence_reorder_buffer.sv
dv/rtp_sequence_reorder_buffer_tb.sv
